// ===== hdl/dpt_pkg.sv =====
// Package for the demand-paged translator: sizes, request modes and status codes.
// Used by dpt_min_unit and demand_paged_translator_lru; depends on nothing.
package dpt_pkg;

    localparam int PROCESSES  = 4;
    localparam int PROC_W     = 2;
    localparam int PAGE_W     = 6;
    localparam int PAGE_BYTES = 4;
    localparam int OFF_W      = 2;
    localparam int FRAMES     = 32;
    localparam int FRAME_W    = 5;
    localparam int IDX_W      = PROC_W + PAGE_W;
    localparam int TOTAL_PAGES = PROCESSES * (1 << PAGE_W);
    localparam int AUX_W      = IDX_W + OFF_W;
    localparam int AUX_DEPTH  = 1 << AUX_W;
    localparam int PHYS_W     = FRAME_W + OFF_W;
    localparam int PHYS_DEPTH = FRAMES * PAGE_BYTES;
    localparam int STAMP_W    = 32;
    localparam int PROT_W     = 3;

    localparam logic [2:0] MODE_READ   = 3'd0;
    localparam logic [2:0] MODE_WRITE  = 3'd1;
    localparam logic [2:0] MODE_EXEC   = 3'd2;
    localparam logic [2:0] MODE_SWITCH = 3'd3;
    localparam logic [2:0] MODE_PROT   = 3'd4;
    localparam logic [2:0] MODE_AUX    = 3'd5;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd4;

endpackage

// ===== hdl/dpt_min_unit.sv =====
// Running minimum of page stamps over the frames for victim selection.
// Depends on dpt_pkg.
module dpt_min_unit (
    input  logic                              i_clk,
    input  logic                              i_sample,
    input  logic [dpt_pkg::FRAME_W-1:0]       i_frame,
    input  logic [dpt_pkg::IDX_W-1:0]         i_owner,
    input  logic [dpt_pkg::STAMP_W-1:0]       i_stamp,
    output logic [dpt_pkg::FRAME_W-1:0]       o_frame,
    output logic [dpt_pkg::IDX_W-1:0]         o_owner
);

    logic [dpt_pkg::STAMP_W-1:0] r_best;
    logic [dpt_pkg::FRAME_W-1:0] r_frame;
    logic [dpt_pkg::IDX_W-1:0]   r_owner;

    always_ff @(posedge i_clk) begin
        if (i_sample && ((i_stamp < r_best) || (i_frame == '0))) begin
            r_best  <= i_stamp;
            r_frame <= i_frame;
            r_owner <= i_owner;
        end
    end

    assign o_frame = r_frame;
    assign o_owner = r_owner;

endmodule

// ===== hdl/demand_paged_translator_lru.sv =====
// Demand-paged translator top: request sequencer, page table, frame and aux stores.
// Depends on dpt_pkg and dpt_min_unit.
//
// One item is worked on at a time; s_axis_tready is high only while the sequencer is idle,
// and a finished result waits in the output register until taken, holding the next result back.
// Process switch, protection set, aux load and invalid modes go straight to the result. An access
// that hits goes through page table read, stamp and permission check and result, with a
// memory read before the result for a read. A fault with a free frame adds the page copy-in.
// A fault with all frames used first scans every frame through the owner and stamp
// memories, then writes a dirty victim back and frees the frame before the copy-in.
// After reset a clearing pass zeroes the aux store, page table and protection before
// the first item.
module demand_paged_translator_lru (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // address[7:0], process[9:8], value[17:10]
    input  logic [2:0]  s_axis_tuser,   // mode[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // status[2:0], read_data[10:3],
                                        // physical_address[17:11], page_fault[18],
                                        // wrote_back[19]
);

    localparam int FW = dpt_pkg::FRAME_W;
    localparam int OW = dpt_pkg::OFF_W;
    localparam int IW = dpt_pkg::IDX_W;
    localparam int SW = dpt_pkg::STAMP_W;
    localparam int PW = dpt_pkg::PROT_W;
    localparam logic [FW:0] FRAMES_N = (FW + 1)'(dpt_pkg::FRAMES);
    localparam logic [OW:0] BYTES_N  = (OW + 1)'(dpt_pkg::PAGE_BYTES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOOKUP, S_SCAN, S_VRD, S_VCHK, S_WB, S_EVICT,
        S_COPY, S_MAP, S_ACCESS, S_RDATA, S_DONE
    } t_state;

    t_state r_state;
    logic [dpt_pkg::AUX_W-1:0] r_cnt;
    logic [2:0]  r_mode;
    logic [7:0]  r_addr;
    logic [7:0]  r_value;
    logic [dpt_pkg::PROC_W-1:0] r_cur_proc;
    logic [SW-1:0] r_time;
    logic [FW:0]   r_fill;
    logic [FW-1:0] r_frame;
    logic [PW-1:0] r_prot;
    logic [IW-1:0] r_victim;
    logic [FW:0]   r_scan;
    logic          r_s1_v, r_s2_v;
    logic [FW-1:0] r_s1_f, r_s2_f;
    logic [IW-1:0] r_s2_owner;
    logic [OW:0]   r_bcnt;
    logic          r_c_v;
    logic [OW-1:0] r_c_i;
    logic [2:0]    r_status;
    logic [7:0]    r_rdata;
    logic          r_fault, r_wb;
    logic          r_ovalid;
    logic [2:0]    r_o_status;
    logic [7:0]    r_o_rdata;
    logic [dpt_pkg::PHYS_W-1:0] r_o_paddr;
    logic          r_o_fault, r_o_wb;

    logic [FW+1:0] page_mem  [dpt_pkg::TOTAL_PAGES];
    logic [PW-1:0] prot_mem  [dpt_pkg::TOTAL_PAGES];
    logic [SW-1:0] stamp_mem [dpt_pkg::TOTAL_PAGES];
    logic [IW-1:0] owner_mem [dpt_pkg::FRAMES];
    logic [7:0]    phys_mem  [dpt_pkg::PHYS_DEPTH];
    logic [7:0]    aux_mem   [dpt_pkg::AUX_DEPTH];
    logic [FW+1:0] r_pm_rd;
    logic [PW-1:0] r_pr_rd;
    logic [SW-1:0] r_st_rd;
    logic [IW-1:0] r_ow_rd;
    logic [7:0]    r_ph_rd;
    logic [7:0]    r_ax_rd;

    logic          accept;
    logic [7:0]    in_addr;
    logic [dpt_pkg::PROC_W-1:0] in_proc;
    logic [7:0]    in_value;
    logic [IW-1:0] idx;
    logic [OW-1:0] off;
    logic          allowed;
    logic          pm_we;
    logic [IW-1:0] pm_wa, pm_ra;
    logic [FW+1:0] pm_wd;
    logic          pr_we;
    logic [IW-1:0] pr_wa;
    logic [PW-1:0] pr_wd;
    logic          st_we;
    logic          ph_we;
    logic [dpt_pkg::PHYS_W-1:0] ph_wa, ph_ra;
    logic [7:0]    ph_wd;
    logic          ax_we;
    logic [dpt_pkg::AUX_W-1:0] ax_wa, ax_ra;
    logic [7:0]    ax_wd;
    logic          copy_issue;
    logic          copy_last;
    logic [FW-1:0] min_frame;
    logic [IW-1:0] min_owner;

    assign in_addr  = s_axis_tdata[7:0];
    assign in_proc  = s_axis_tdata[9:8];
    assign in_value = s_axis_tdata[17:10];
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign idx     = {r_cur_proc, r_addr[7:OW]};
    assign off     = r_addr[OW-1:0];
    assign allowed = r_prot[r_mode[1:0]];
    assign copy_issue = (r_bcnt < BYTES_N);
    assign copy_last  = r_c_v && (r_c_i == OW'(dpt_pkg::PAGE_BYTES - 1));

    always_comb begin
        pm_we = 1'b0;
        pm_wa = idx;
        pm_wd = '0;
        pm_ra = {r_cur_proc, in_addr[7:OW]};
        pr_we = 1'b0;
        pr_wa = {in_proc, in_addr[7:OW]};
        pr_wd = in_value[PW-1:0];
        st_we = 1'b0;
        ph_we = 1'b0;
        ph_wa = {r_frame, r_c_i};
        ph_wd = r_ax_rd;
        ph_ra = {r_frame, r_bcnt[OW-1:0]};
        ax_we = 1'b0;
        ax_wa = {in_proc, in_addr};
        ax_wd = in_value;
        ax_ra = {idx, r_bcnt[OW-1:0]};
        case (r_state)
            S_CLEAR: begin
                ax_we = 1'b1;
                ax_wa = r_cnt;
                ax_wd = '0;
                pm_we = (r_cnt[dpt_pkg::AUX_W-1:IW] == '0);
                pm_wa = r_cnt[IW-1:0];
                pr_we = pm_we;
                pr_wa = r_cnt[IW-1:0];
                pr_wd = '0;
            end
            S_IDLE: begin
                pr_we = accept && (s_axis_tuser == dpt_pkg::MODE_PROT);
                ax_we = accept && (s_axis_tuser == dpt_pkg::MODE_AUX);
            end
            S_VRD: begin
                pm_ra = min_owner;
            end
            S_WB: begin
                ax_we = r_c_v;
                ax_wa = {r_victim, r_c_i};
                ax_wd = r_ph_rd;
            end
            S_EVICT: begin
                pm_we = 1'b1;
                pm_wa = r_victim;
                pm_wd = {2'b00, r_frame};
            end
            S_COPY: begin
                ph_we = r_c_v;
            end
            S_MAP: begin
                pm_we = 1'b1;
                pm_wd = {2'b10, r_frame};
            end
            S_ACCESS: begin
                st_we = 1'b1;
                ph_ra = {r_frame, off};
                ph_wa = {r_frame, off};
                ph_wd = r_value;
                if (allowed && (r_mode == dpt_pkg::MODE_WRITE)) begin
                    ph_we = 1'b1;
                    pm_we = 1'b1;
                    pm_wd = {2'b11, r_frame};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pm_we) page_mem[pm_wa] <= pm_wd;
        r_pm_rd <= page_mem[pm_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pr_we) prot_mem[pr_wa] <= pr_wd;
        r_pr_rd <= prot_mem[pm_ra];
    end

    always_ff @(posedge i_clk) begin
        if (st_we) stamp_mem[idx] <= r_time;
        r_st_rd <= stamp_mem[r_ow_rd];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MAP) owner_mem[r_frame] <= idx;
        r_ow_rd <= owner_mem[r_scan[FW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (ph_we) phys_mem[ph_wa] <= ph_wd;
        r_ph_rd <= phys_mem[ph_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ax_we) aux_mem[ax_wa] <= ax_wd;
        r_ax_rd <= aux_mem[ax_ra];
    end

    dpt_min_unit u_min (
        .i_clk    (i_clk),
        .i_sample (r_s2_v),
        .i_frame  (r_s2_f),
        .i_owner  (r_s2_owner),
        .i_stamp  (r_st_rd),
        .o_frame  (min_frame),
        .o_owner  (min_owner)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_cnt      <= '0;
            r_cur_proc <= '0;
            r_time     <= SW'(1);
            r_fill     <= '0;
            r_ovalid   <= 1'b0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_c_v      <= 1'b0;
            r_scan     <= '0;
            r_bcnt     <= '0;
        end else begin
            r_s1_v     <= (r_state == S_SCAN) && (r_scan < FRAMES_N);
            r_s2_v     <= r_s1_v;
            r_s2_f     <= r_s1_f;
            r_s2_owner <= r_ow_rd;
            r_c_v      <= ((r_state == S_WB) || (r_state == S_COPY)) && copy_issue;
            r_c_i      <= r_bcnt[OW-1:0];
            if (m_axis_tvalid && m_axis_tready && (r_state != S_DONE)) r_ovalid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == dpt_pkg::AUX_W'(dpt_pkg::AUX_DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (accept) begin
                        r_mode   <= s_axis_tuser;
                        r_addr   <= in_addr;
                        r_value  <= in_value;
                        r_status <= dpt_pkg::ST_OK;
                        r_rdata  <= '0;
                        r_fault  <= 1'b0;
                        r_wb     <= 1'b0;
                        r_frame  <= '0;
                        if (s_axis_tuser <= dpt_pkg::MODE_EXEC) begin
                            r_state <= S_LOOKUP;
                        end else begin
                            r_state <= S_DONE;
                            if (s_axis_tuser == dpt_pkg::MODE_SWITCH) r_cur_proc <= in_proc;
                            if (s_axis_tuser > dpt_pkg::MODE_AUX) r_status <= dpt_pkg::ST_INVALID;
                        end
                    end
                end
                S_LOOKUP: begin
                    r_prot <= r_pr_rd;
                    r_bcnt <= '0;
                    r_scan <= '0;
                    if (r_pm_rd[FW+1]) begin
                        r_frame <= r_pm_rd[FW-1:0];
                        r_state <= S_ACCESS;
                    end else if (r_fill < FRAMES_N) begin
                        r_frame <= r_fill[FW-1:0];
                        r_fill  <= r_fill + 1'b1;
                        r_state <= S_COPY;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_scan < FRAMES_N) begin
                        r_s1_f <= r_scan[FW-1:0];
                        r_scan <= r_scan + 1'b1;
                    end
                    if (r_s2_v && (r_s2_f == FW'(dpt_pkg::FRAMES - 1))) r_state <= S_VRD;
                end
                S_VRD: begin
                    r_frame  <= min_frame;
                    r_victim <= min_owner;
                    r_state  <= S_VCHK;
                end
                S_VCHK: begin
                    r_wb    <= r_pm_rd[FW];
                    r_bcnt  <= '0;
                    r_state <= r_pm_rd[FW] ? S_WB : S_EVICT;
                end
                S_WB: begin
                    if (copy_issue) begin
                        r_bcnt <= r_bcnt + 1'b1;
                    end
                    if (copy_last) r_state <= S_EVICT;
                end
                S_EVICT: begin
                    r_bcnt  <= '0;
                    r_state <= S_COPY;
                end
                S_COPY: begin
                    if (copy_issue) begin
                        r_bcnt <= r_bcnt + 1'b1;
                    end
                    if (copy_last) r_state <= S_MAP;
                end
                S_MAP: begin
                    r_fault <= 1'b1;
                    r_state <= S_ACCESS;
                end
                S_ACCESS: begin
                    r_time <= r_time + 1'b1;
                    if (!allowed) begin
                        r_status <= 3'(r_mode + 3'd1);
                        r_state  <= S_DONE;
                    end else if (r_mode == dpt_pkg::MODE_READ) begin
                        r_state <= S_RDATA;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_RDATA: begin
                    r_rdata <= r_ph_rd;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid   <= 1'b1;
                        r_o_status <= r_status;
                        r_o_rdata  <= r_rdata;
                        r_o_paddr  <= (r_mode <= dpt_pkg::MODE_EXEC) ? {r_frame, off} : '0;
                        r_o_fault  <= r_fault;
                        r_o_wb     <= r_wb;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'd0, r_o_wb, r_o_fault, r_o_paddr, r_o_rdata, r_o_status};

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FRAMES_N)
        else $error("frame fill count beyond frame count");
    a_scan_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_fill == FRAMES_N))
        else $error("victim scan with a free frame left");
    a_wb_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[19]) |-> m_axis_tdata[18])
        else $error("write-back without page fault");
    a_invalid_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[2:0] == dpt_pkg::ST_INVALID))
            |-> (m_axis_tdata[19:3] == '0))
        else $error("invalid mode result carries data");
`endif

endmodule
